>>> src/i64da_pkg.sv
// ----------------------------------------------------------------------------
// i64da_pkg
// Shared widths, character codes and types of the integer-to-decimal block.
// ----------------------------------------------------------------------------
package i64da_pkg;

    localparam int ValueWidth = 64;
    localparam int NumDigits  = 20;
    localparam int DigitWidth = 4;
    localparam int CharWidth  = 6;
    localparam int LenWidth   = 5;
    localparam int CntWidth   = 7;

    localparam logic [CntWidth-1:0]  BitSteps  = 7'd64;
    localparam logic [CharWidth-1:0] CharMinus = 6'd45;
    localparam logic [CharWidth-1:0] CharZero  = 6'd48;

    // bcd digits, index 0 is the least significant
    typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_t;

    // hand-off from the converter to the character emitter
    typedef struct packed {
        logic                done;
        logic                neg;
        logic [LenWidth-1:0] ndig;
    } conv_status_t;

endpackage

>>> src/i64da_in_if.sv
// ----------------------------------------------------------------------------
// i64da_in_if
// Input channel: one signed 64-bit value per request.
// ----------------------------------------------------------------------------
interface i64da_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [i64da_pkg::ValueWidth-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

>>> src/i64da_out_if.sv
// ----------------------------------------------------------------------------
// i64da_out_if
// Output channel: one text character per request.
// ----------------------------------------------------------------------------
interface i64da_out_if;

    logic                             valid;
    logic                             ready;
    logic [i64da_pkg::CharWidth-1:0]  char_code;
    logic [i64da_pkg::LenWidth-1:0]   text_length;
    logic                             last_char;

    modport source (output valid, output char_code, output text_length,
                    output last_char, input ready);
    modport sink   (input valid, input char_code, input text_length,
                    input last_char, output ready);

endinterface

>>> src/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Signed 64-bit integer to decimal ASCII text, one character per request.
// ----------------------------------------------------------------------------
// One value is taken when number.ready is high, which holds only while no
// conversion or text is in progress. The magnitude then goes through a
// bit-serial shift-and-add-3 converter, one bit per cycle, after which
// characters leave through an output register one per cycle while the
// output accepts them: a '-' for negative values, then the digits, most
// significant first, each with the total text length and a flag on the last
// one.
module int64_to_decimal_ascii (
    input  logic         clk,
    input  logic         rst_n,
    i64da_in_if.sink     number,
    i64da_out_if.source  text
);

    logic                    conv_busy;
    logic                    emit_busy;
    logic                    start;
    i64da_pkg::bcd_t         digits;
    i64da_pkg::conv_status_t status;

    // one value at a time through the converter and emitter
    assign number.ready = !conv_busy && !emit_busy;
    assign start        = number.valid && number.ready;

    i64da_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (number.value),
        .busy   (conv_busy),
        .digits (digits),
        .status (status)
    );

    i64da_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .digits (digits),
        .busy   (emit_busy),
        .text   (text)
    );

endmodule

>>> src/i64da_conv.sv
// ----------------------------------------------------------------------------
// i64da_conv
// Bit-serial binary to bcd converter (shift and add-3), one bit per cycle,
// with a running count of significant decimal digits.
// ----------------------------------------------------------------------------
module i64da_conv (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [i64da_pkg::ValueWidth-1:0] value,
    output logic                                    busy,
    output i64da_pkg::bcd_t                         digits,
    output i64da_pkg::conv_status_t                 status
);

    logic [i64da_pkg::ValueWidth-1:0]  mag_reg, mag_next;
    i64da_pkg::bcd_t                   bcd_reg, bcd_next;
    logic [i64da_pkg::CntWidth-1:0]    cnt_reg, cnt_next;
    logic [i64da_pkg::LenWidth-1:0]    ndig_reg, ndig_next;
    logic                              neg_reg, neg_next;
    logic                              done_reg, done_next;

    i64da_pkg::bcd_t                   adj;
    logic [i64da_pkg::NumDigits*i64da_pkg::DigitWidth:0] wide;
    i64da_pkg::bcd_t                   shifted;

    // add 3 to every digit of five or more, then shift the next bit in
    always_comb
    begin
        for (int i = 0; i < i64da_pkg::NumDigits; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
            begin
                adj[i] = bcd_reg[i] + 4'd3;
            end
            else
            begin
                adj[i] = bcd_reg[i];
            end
        end
        wide    = {adj, mag_reg[i64da_pkg::ValueWidth-1]};
        shifted = wide[i64da_pkg::NumDigits*i64da_pkg::DigitWidth-1:0];
    end

    // next-state logic
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        ndig_next = ndig_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = value[i64da_pkg::ValueWidth-1];
            mag_next  = value[i64da_pkg::ValueWidth-1] ?
                        (64'd0 - $unsigned(value)) : $unsigned(value);
            bcd_next  = '0;
            cnt_next  = i64da_pkg::BitSteps;
            ndig_next = 5'd1;
        end
        else if (cnt_reg != '0)
        begin
            mag_next = {mag_reg[i64da_pkg::ValueWidth-2:0], 1'b0};
            bcd_next = shifted;
            cnt_next = cnt_reg - 7'd1;
            // doubling adds at most one digit: look just above the current top
            if (ndig_reg < 5'(i64da_pkg::NumDigits))
            begin
                if (shifted[ndig_reg] != '0)
                begin
                    ndig_next = ndig_reg + 5'd1;
                end
            end
            done_next = (cnt_reg == 7'd1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        ndig_reg <= ndig_next;
        neg_reg  <= neg_next;
    end

    assign busy        = (cnt_reg != '0) || done_reg;
    assign digits      = bcd_reg;
    assign status.done = done_reg;
    assign status.neg  = neg_reg;
    assign status.ndig = ndig_reg;

    // digit count stays within the text while a conversion runs
    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (ndig_reg >= 5'd1 &&
                             ndig_reg <= 5'(i64da_pkg::NumDigits)))
        else $error("digit count out of range");

    // done comes in the cycle after the last shift step
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cnt_reg) == 7'd1)
        else $error("done without final shift step");

    // a new value is loaded only when no conversion runs
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (cnt_reg == '0 && !done_reg))
        else $error("start while converting");

endmodule

>>> src/i64da_emit.sv
// ----------------------------------------------------------------------------
// i64da_emit
// Character emitter: sign, then bcd digits from the most significant,
// one character per cycle into an output register while the output is ready.
// ----------------------------------------------------------------------------
module i64da_emit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  i64da_pkg::conv_status_t status,
    input  i64da_pkg::bcd_t         digits,
    output logic                    busy,
    i64da_out_if.source             text
);

    logic [i64da_pkg::LenWidth-1:0]  total_reg, total_next;
    logic [i64da_pkg::LenWidth-1:0]  rem_reg, rem_next;
    logic [i64da_pkg::LenWidth-1:0]  idx_reg, idx_next;
    logic                            sign_reg, sign_next;
    logic                            ovalid_reg, ovalid_next;
    logic [i64da_pkg::CharWidth-1:0] char_reg, char_next;
    logic                            last_reg, last_next;
    logic                            produce;
    logic [i64da_pkg::LenWidth-1:0]  total_calc;

    assign total_calc = status.ndig + {4'd0, status.neg};
    assign produce    = (rem_reg != '0) && (!ovalid_reg || text.ready);

    // next-state logic
    always_comb
    begin
        total_next  = total_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        sign_next   = sign_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !text.ready;
        if (status.done)
        begin
            total_next = total_calc;
            rem_next   = total_calc;
            idx_next   = status.ndig - 5'd1;
            sign_next  = status.neg;
        end
        else if (produce)
        begin
            ovalid_next = 1'b1;
            last_next   = (rem_reg == 5'd1);
            rem_next    = rem_reg - 5'd1;
            if (sign_reg)
            begin
                char_next = i64da_pkg::CharMinus;
                sign_next = 1'b0;
            end
            else
            begin
                char_next = i64da_pkg::CharZero + {2'd0, digits[idx_reg]};
                idx_next  = idx_reg - 5'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        idx_reg   <= idx_next;
        sign_reg  <= sign_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign busy             = (rem_reg != '0) || ovalid_reg;
    assign text.valid       = ovalid_reg;
    assign text.char_code   = char_reg;
    assign text.text_length = total_reg;
    assign text.last_char   = last_reg;

    // characters left never exceed the text length
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> rem_reg <= total_reg)
        else $error("remaining count above text length");

    // a new text starts only after the previous one has drained
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> !busy)
        else $error("new text while emitting");

    // the last character is registered exactly when the count runs out
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> (last_reg == (rem_reg == '0)))
        else $error("last flag out of step with count");

endmodule
